// ===== rtl/core/echo_pulse_range_meter_defines.svh =====
// ----------------------------------------------------------------------------
// echo_pulse_range_meter_defines
// assertion macros used by the range meter core
// ----------------------------------------------------------------------------
`ifndef ECHO_PULSE_RANGE_METER_DEFINES_SVH
`define ECHO_PULSE_RANGE_METER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define EPR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define EPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/epr_pkg.sv =====
// ----------------------------------------------------------------------------
// epr_pkg
// shared constants, types and helpers of the echo pulse range meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epr_pkg;

	// width of the phase and echo counters
	localparam int CountWidth = 22;
	localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

	// wide enough to compare any counter against any register
	localparam int CmpWidth = 33;

	localparam int EnableWidth  = 1;
	localparam int TrigWidth    = 10;
	localparam int TimeoutWidth = 22;
	localparam int CfgDataWidth = 22;
	localparam int CfgIndexWidth = 2;

	localparam int DistWidth = 16;
	localparam int EchoWidth = 22;
	localparam logic [DistWidth-1:0] DistMax = {DistWidth{1'b1}};
	localparam logic [EchoWidth-1:0] EchoMax = {EchoWidth{1'b1}};

	localparam logic [TrigWidth-1:0]    TrigReset    = 10'd10;
	localparam logic [TimeoutWidth-1:0] TimeoutReset = 22'd3000000;

	// register indexes
	localparam logic [CfgIndexWidth-1:0] REG_ENABLE  = 2'd0;
	localparam logic [CfgIndexWidth-1:0] REG_TRIGGER = 2'd1;
	localparam logic [CfgIndexWidth-1:0] REG_TIMEOUT = 2'd2;

	// cm = echo / 58 = (echo >> 1) / 29, done with a reciprocal multiply
	localparam int CmHalfDivisor = 29;
	localparam int RecipShift = CountWidth + 4;
	localparam logic [CountWidth-1:0] Recip =
		CountWidth'((64'd1 << RecipShift) / 64'(CmHalfDivisor) + 64'd1);
	localparam int ProdWidth = (CountWidth - 1) + CountWidth;
	localparam int QuotWidth = ProdWidth - RecipShift;

	typedef struct packed {
		logic                    enable;
		logic [TrigWidth-1:0]    trigger_ticks;
		logic [TimeoutWidth-1:0] timeout_ticks;
	} cfg_t;

	function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
		sat_inc = (v == CountMax) ? v : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/epr_in_if.sv =====
// ----------------------------------------------------------------------------
// epr_in_if
// sample channel: one echo level item per microsecond tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface epr_in_if;
	logic valid;
	logic ready;
	logic echo_level;

	modport source (output valid, output echo_level, input ready);
	modport sink (input valid, input echo_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/epr_out_if.sv =====
// ----------------------------------------------------------------------------
// epr_out_if
// result channel: one item per accepted tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface epr_out_if;
	logic                              valid;
	logic                              ready;
	logic                              trigger_out;
	logic                              distance_valid;
	logic [epr_pkg::DistWidth-1:0]     distance_cm;
	logic [epr_pkg::EchoWidth-1:0]     echo_time_us;
	logic                              timed_out;

	modport source (output valid, output trigger_out, output distance_valid,
		output distance_cm, output echo_time_us, output timed_out, input ready);
	modport sink (input valid, input trigger_out, input distance_valid,
		input distance_cm, input echo_time_us, input timed_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/echo_pulse_range_meter.sv =====
// Ultrasonic echo pulse range meter. Feed one sample item per microsecond tick
// and take one result item back for each. The sequencer drives trigger_out
// for trigger_ticks items (one if zero), waits for the echo to rise, counts
// the high ticks and reports echo_time_us and distance_cm (echo time / 58)
// with distance_valid on the tick the echo falls, then passes one idle tick
// and re-triggers. When wait plus measure exceeds timeout_ticks it raises
// timed_out instead. One item is taken every clock cycle while the result
// is not stalled, since the whole phase update and the divide-by-58 multiply
// sit between the sample register and the result register; each sample
// passes through the sample register into the result register, and a
// stalled result holds off further samples.
// Writing enable to zero holds the block in its reset state.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// echo_pulse_range_meter
// top level: configuration registers and range measurement core
// ----------------------------------------------------------------------------

module echo_pulse_range_meter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [epr_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  wire logic [epr_pkg::CfgDataWidth-1:0]   cfg_data,
	epr_in_if.sink                                  sample,
	epr_out_if.source                               result
);

	epr_pkg::cfg_t cfg;

	epr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	epr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== rtl/core/epr_regs.sv =====
// ----------------------------------------------------------------------------
// epr_regs
// configuration registers with their reset values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epr_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [epr_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  wire logic [epr_pkg::CfgDataWidth-1:0]   cfg_data,
	output epr_pkg::cfg_t                           cfg
);

	epr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b1;
			cfg_q.trigger_ticks <= epr_pkg::TrigReset;
			cfg_q.timeout_ticks <= epr_pkg::TimeoutReset;
		end else if (cfg_we) begin
			case (cfg_index)
				epr_pkg::REG_ENABLE: begin
					cfg_q.enable <= cfg_data[0];
				end
				epr_pkg::REG_TRIGGER: begin
					cfg_q.trigger_ticks <= cfg_data[epr_pkg::TrigWidth-1:0];
				end
				epr_pkg::REG_TIMEOUT: begin
					cfg_q.timeout_ticks <= cfg_data[epr_pkg::TimeoutWidth-1:0];
				end
				default: begin
					// writes to unused indexes are dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/epr_cm_conv.sv =====
// ----------------------------------------------------------------------------
// epr_cm_conv
// echo count to reported echo time and distance in cm (divide by 58)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epr_cm_conv (
	input  wire logic [epr_pkg::CountWidth-1:0] echo_count,
	output logic      [epr_pkg::DistWidth-1:0]  distance_cm,
	output logic      [epr_pkg::EchoWidth-1:0]  echo_time_us
);

	logic [epr_pkg::CountWidth-2:0] half;
	logic [epr_pkg::ProdWidth-1:0]  prod;
	logic [epr_pkg::QuotWidth-1:0]  quot;

	// reciprocal of 29 is exact for every half count that fits the counter
	assign half = echo_count[epr_pkg::CountWidth-1:1];
	assign prod = epr_pkg::ProdWidth'(half) * epr_pkg::ProdWidth'(epr_pkg::Recip);
	assign quot = prod[epr_pkg::ProdWidth-1:epr_pkg::RecipShift];

	assign distance_cm =
		(epr_pkg::CmpWidth'(quot) > epr_pkg::CmpWidth'(epr_pkg::DistMax))
			? epr_pkg::DistMax : epr_pkg::DistWidth'(quot);

	assign echo_time_us =
		(epr_pkg::CmpWidth'(echo_count) > epr_pkg::CmpWidth'(epr_pkg::EchoMax))
			? epr_pkg::EchoMax : epr_pkg::EchoWidth'(echo_count);

endmodule

`default_nettype wire

// ===== rtl/core/epr_core.sv =====
// ----------------------------------------------------------------------------
// epr_core
// sample register, phase sequencer and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "echo_pulse_range_meter_defines.svh"

module epr_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire epr_pkg::cfg_t cfg,
	epr_in_if.sink             sample,
	epr_out_if.source          result
);

	typedef enum logic [1:0] {
		PH_TRIGGER,
		PH_WAIT,
		PH_MEASURE,
		PH_DONE
	} phase_t;

	localparam int CW = epr_pkg::CountWidth;
	localparam int CMW = epr_pkg::CmpWidth;

	// input stage
	logic valid_s1;
	logic echo_s1;
	logic adv;
	logic in_ready;

	// sequencer state and result register
	phase_t          phase_q;
	logic [CW-1:0]   elapsed_q;
	logic [CW-1:0]   count_q;
	logic            out_valid_q;
	logic            trig_q;
	logic            dvalid_q;
	logic [epr_pkg::DistWidth-1:0] dist_q;
	logic [epr_pkg::EchoWidth-1:0] etime_q;
	logic            tmo_q;

	// next values
	phase_t          phase_d;
	logic [CW-1:0]   elapsed_d;
	logic [CW-1:0]   count_d;
	logic            trig_d;
	logic            dvalid_d;
	logic [epr_pkg::DistWidth-1:0] dist_d;
	logic [epr_pkg::EchoWidth-1:0] etime_d;
	logic            tmo_d;

	logic [CW-1:0]   elapsed_inc;
	logic [epr_pkg::TrigWidth-1:0] trig_len;
	logic [epr_pkg::DistWidth-1:0] conv_dist;
	logic [epr_pkg::EchoWidth-1:0] conv_etime;

	assign adv      = valid_s1 && (!out_valid_q || result.ready);
	assign in_ready = !valid_s1 || adv;
	assign sample.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			echo_s1  <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= sample.valid;
			echo_s1  <= sample.echo_level;
		end
	end

	epr_cm_conv u_cm_conv (
		.echo_count   (count_q),
		.distance_cm  (conv_dist),
		.echo_time_us (conv_etime)
	);

	assign elapsed_inc = epr_pkg::sat_inc(elapsed_q);
	assign trig_len = (cfg.trigger_ticks == '0) ? epr_pkg::TrigWidth'(1)
		: cfg.trigger_ticks;

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		count_d   = count_q;
		trig_d    = 1'b0;
		dvalid_d  = 1'b0;
		dist_d    = '0;
		etime_d   = '0;
		tmo_d     = 1'b0;
		if (!cfg.enable) begin
			phase_d   = PH_TRIGGER;
			elapsed_d = '0;
			count_d   = '0;
		end else begin
			case (phase_q)
				PH_TRIGGER: begin
					trig_d = 1'b1;
					if (CMW'(elapsed_inc) >= CMW'(trig_len)) begin
						phase_d   = PH_WAIT;
						elapsed_d = '0;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
				PH_WAIT, PH_MEASURE: begin
					if (phase_q == PH_MEASURE && !echo_s1) begin
						// falling edge wins over a timeout on the same tick
						dvalid_d  = 1'b1;
						dist_d    = conv_dist;
						etime_d   = conv_etime;
						phase_d   = PH_DONE;
						elapsed_d = '0;
						count_d   = '0;
					end else if (CMW'(elapsed_inc) > CMW'(cfg.timeout_ticks)) begin
						tmo_d     = 1'b1;
						phase_d   = PH_DONE;
						elapsed_d = '0;
						count_d   = '0;
					end else begin
						elapsed_d = elapsed_inc;
						if (echo_s1) begin
							// rise tick counts as one
							count_d = (phase_q == PH_WAIT) ? CW'(1)
								: epr_pkg::sat_inc(count_q);
							phase_d = PH_MEASURE;
						end
					end
				end
				default: begin
					phase_d   = PH_TRIGGER;
					elapsed_d = '0;
					count_d   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TRIGGER;
			elapsed_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			trig_q      <= 1'b0;
			dvalid_q    <= 1'b0;
			dist_q      <= '0;
			etime_q     <= '0;
			tmo_q       <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_d;
			elapsed_q   <= elapsed_d;
			count_q     <= count_d;
			out_valid_q <= 1'b1;
			trig_q      <= trig_d;
			dvalid_q    <= dvalid_d;
			dist_q      <= dist_d;
			etime_q     <= etime_d;
			tmo_q       <= tmo_d;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.trigger_out    = trig_q;
	assign result.distance_valid = dvalid_q;
	assign result.distance_cm    = dist_q;
	assign result.echo_time_us   = etime_q;
	assign result.timed_out      = tmo_q;

	`EPR_ASSERT_SAME(a_measure_has_count, phase_q == PH_MEASURE, count_q != '0,
		"measuring with zero echo count")
	`EPR_ASSERT_NEXT(a_disabled_quiet, adv && !cfg.enable,
		!trig_q && !dvalid_q && !tmo_q && phase_q == PH_TRIGGER, "disabled item not quiet")
	`EPR_ASSERT_SAME(a_flags_exclusive, out_valid_q,
		!(dvalid_q && tmo_q) && !(trig_q && (dvalid_q || tmo_q)), "result flags overlap")
	`EPR_ASSERT_SAME(a_no_stale_payload, out_valid_q && !dvalid_q,
		dist_q == '0 && etime_q == '0, "payload without distance_valid")
	`EPR_ASSERT_SAME(a_cm_quotient, out_valid_q && dvalid_q && dist_q != epr_pkg::DistMax,
		(24'(dist_q) * 24'd58 <= 24'(etime_q)) && (24'(etime_q) < 24'(dist_q) * 24'd58 + 24'd58),
		"distance does not match echo time")

endmodule

`default_nettype wire

// ===== sim/tb_echo_pulse_range_meter.sv =====
// ----------------------------------------------------------------------------
// tb_echo_pulse_range_meter
// self-checking bench for the echo pulse range meter: echo level items are
// fed one per tick with random gaps and result stalls, a local model of the
// trigger, wait, measure and done sequence predicts every result item, and a
// monitor compares each returned item field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_echo_pulse_range_meter;

	typedef enum logic [1:0] {
		ST_TRIGGER   = 2'd0,
		ST_WAIT_RISE = 2'd1,
		ST_MEASURE   = 2'd2,
		ST_DONE      = 2'd3
	} meter_phase_t;

	typedef struct packed {
		logic                          trigger_out;
		logic                          distance_valid;
		logic [epr_pkg::DistWidth-1:0] distance_cm;
		logic [epr_pkg::EchoWidth-1:0] echo_time_us;
		logic                          timed_out;
	} range_result_t;

	localparam int CmDivisor = 58;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [epr_pkg::CfgIndexWidth-1:0] cfg_index;
	logic [epr_pkg::CfgDataWidth-1:0]  cfg_data;

	epr_in_if  echo_in ();
	epr_out_if meter_out ();

	echo_pulse_range_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (echo_in),
		.result    (meter_out)
	);

	// local copy of the configuration and sequencer state
	logic                             cfg_enable      = 1'b1;
	logic [epr_pkg::TrigWidth-1:0]    cfg_trigger_len = epr_pkg::TrigReset;
	logic [epr_pkg::TimeoutWidth-1:0] cfg_timeout     = epr_pkg::TimeoutReset;
	meter_phase_t                     meter_phase     = ST_TRIGGER;
	logic [epr_pkg::CountWidth-1:0]   phase_ticks     = '0;
	logic [epr_pkg::CountWidth-1:0]   echo_ticks      = '0;

	range_result_t pending_readings[$];
	int            mismatch_count = 0;
	int            live_items     = 0;
	bit            quiet          = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("[echo_pulse_range_meter] ERROR");
		$finish;
	end

	function automatic logic [epr_pkg::CountWidth-1:0] bump_count(
			input logic [epr_pkg::CountWidth-1:0] v);
		return (v == {epr_pkg::CountWidth{1'b1}}) ? v : v + 1'b1;
	endfunction

	// advance the local sequencer by one tick and return the reading it gives
	function automatic range_result_t step_meter(input logic echo);
		range_result_t                  r;
		logic [epr_pkg::CountWidth-1:0] nxt;
		logic [epr_pkg::TrigWidth-1:0]  len;
		logic [epr_pkg::CountWidth-1:0] quot;
		r = '0;
		if (!cfg_enable) begin
			meter_phase = ST_TRIGGER;
			phase_ticks = '0;
			echo_ticks  = '0;
		end else begin
			case (meter_phase)
				ST_TRIGGER: begin
					r.trigger_out = 1'b1;
					len = (cfg_trigger_len == '0) ? epr_pkg::TrigWidth'(1) : cfg_trigger_len;
					nxt = bump_count(phase_ticks);
					if (epr_pkg::CmpWidth'(nxt) >= epr_pkg::CmpWidth'(len)) begin
						meter_phase = ST_WAIT_RISE;
						phase_ticks = '0;
					end else begin
						phase_ticks = nxt;
					end
				end
				ST_WAIT_RISE, ST_MEASURE: begin
					nxt = bump_count(phase_ticks);
					// a falling edge wins over a timeout on the same tick
					if (meter_phase == ST_MEASURE && !echo) begin
						r.distance_valid = 1'b1;
						r.echo_time_us   =
							(epr_pkg::CmpWidth'(echo_ticks) > epr_pkg::CmpWidth'(epr_pkg::EchoMax))
							? epr_pkg::EchoMax : epr_pkg::EchoWidth'(echo_ticks);
						quot             = epr_pkg::CountWidth'(echo_ticks / CmDivisor);
						r.distance_cm    =
							(epr_pkg::CmpWidth'(quot) > epr_pkg::CmpWidth'(epr_pkg::DistMax))
							? epr_pkg::DistMax : epr_pkg::DistWidth'(quot);
						meter_phase = ST_DONE;
						phase_ticks = '0;
						echo_ticks  = '0;
					end else if (epr_pkg::CmpWidth'(nxt) > epr_pkg::CmpWidth'(cfg_timeout)) begin
						r.timed_out = 1'b1;
						meter_phase = ST_DONE;
						phase_ticks = '0;
						echo_ticks  = '0;
					end else begin
						phase_ticks = nxt;
						if (echo) begin
							echo_ticks = (meter_phase == ST_WAIT_RISE)
								? epr_pkg::CountWidth'(1) : bump_count(echo_ticks);
							meter_phase = ST_MEASURE;
						end
					end
				end
				default: begin
					meter_phase = ST_TRIGGER;
					phase_ticks = '0;
					echo_ticks  = '0;
				end
			endcase
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_monitor
		range_result_t want;
		if (arst_n && meter_out.valid && meter_out.ready) begin
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result item, expected none actual trig=%0b valid=%0b",
					$time, meter_out.trigger_out, meter_out.distance_valid);
			end else begin
				want = pending_readings.pop_front();
				check_field("trigger_out", 32'(want.trigger_out),
					32'(meter_out.trigger_out));
				check_field("distance_valid", 32'(want.distance_valid),
					32'(meter_out.distance_valid));
				check_field("distance_cm", 32'(want.distance_cm),
					32'(meter_out.distance_cm));
				check_field("echo_time_us", 32'(want.echo_time_us),
					32'(meter_out.echo_time_us));
				check_field("timed_out", 32'(want.timed_out), 32'(meter_out.timed_out));
			end
		end
	end

	initial begin
		meter_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			meter_out.ready <= quiet || ($urandom_range(99) >= 27);
		end
	end

	task automatic send_echo(input logic lvl);
		if (!quiet && $urandom_range(99) < 27) begin
			echo_in.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 27);
		end
		echo_in.valid      <= 1'b1;
		echo_in.echo_level <= lvl;
		do @(posedge clk); while (!echo_in.ready);
		if (meter_phase == ST_WAIT_RISE || meter_phase == ST_MEASURE)
			live_items++;
		pending_readings.push_back(step_meter(lvl));
	endtask

	// drain all outstanding items so the block is idle
	task automatic settle();
		echo_in.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [epr_pkg::CfgIndexWidth-1:0] idx,
			input logic [epr_pkg::CfgDataWidth-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			epr_pkg::REG_ENABLE:  cfg_enable      = value[0];
			epr_pkg::REG_TRIGGER: cfg_trigger_len = value[epr_pkg::TrigWidth-1:0];
			epr_pkg::REG_TIMEOUT: cfg_timeout     = value[epr_pkg::TimeoutWidth-1:0];
			default: ;
		endcase
	endtask

	// echo is ignored during trigger and done, so feed it random levels
	task automatic skip_to_wait();
		while (meter_phase == ST_TRIGGER || meter_phase == ST_DONE)
			send_echo(1'($urandom_range(1)));
	endtask

	task automatic echo_pulse(input int gap, input int width);
		skip_to_wait();
		repeat (gap) send_echo(1'b0);
		repeat (width) send_echo(1'b1);
		send_echo(1'b0);
	endtask

	task automatic test_counting_edges();
		echo_pulse(3, 1);
		echo_pulse(0, 57);
		echo_pulse(1, 58);
		echo_pulse(2, 116);
	endtask

	task automatic test_trigger_lengths();
		settle();
		write_reg(epr_pkg::REG_TRIGGER, '0);
		echo_pulse(1, 5);
		settle();
		write_reg(epr_pkg::REG_TRIGGER, epr_pkg::CfgDataWidth'(1));
		echo_pulse(0, 3);
		settle();
		write_reg(epr_pkg::REG_TRIGGER, epr_pkg::CfgDataWidth'(300));
		echo_pulse(2, 60);
		settle();
		write_reg(epr_pkg::REG_TRIGGER, epr_pkg::CfgDataWidth'(1));
	endtask

	task automatic test_timeouts();
		settle();
		write_reg(epr_pkg::REG_TIMEOUT, epr_pkg::CfgDataWidth'(20));
		// fall on the tick the timeout would expire
		skip_to_wait();
		repeat (20) send_echo(1'b1);
		send_echo(1'b0);
		// echo held high one tick too long
		skip_to_wait();
		repeat (21) send_echo(1'b1);
		// echo never rises
		skip_to_wait();
		repeat (22) send_echo(1'b0);
		settle();
		write_reg(epr_pkg::REG_TIMEOUT, '0);
		skip_to_wait();
		send_echo(1'b1);
		settle();
		write_reg(epr_pkg::REG_TIMEOUT, epr_pkg::CfgDataWidth'(1));
		skip_to_wait();
		send_echo(1'b1);
		send_echo(1'b0);
		settle();
		write_reg(epr_pkg::REG_TIMEOUT,
			epr_pkg::CfgDataWidth'({epr_pkg::TimeoutWidth{1'b1}}));
		echo_pulse(5, 100);
	endtask

	task automatic test_disable();
		settle();
		write_reg(epr_pkg::REG_ENABLE, epr_pkg::CfgDataWidth'(0));
		repeat (6) send_echo(1'($urandom_range(1)));
		settle();
		write_reg(epr_pkg::REG_ENABLE, epr_pkg::CfgDataWidth'(1));
		echo_pulse(2, 30);
		// drop enable in the middle of a measurement
		skip_to_wait();
		repeat (4) send_echo(1'b1);
		settle();
		write_reg(epr_pkg::REG_ENABLE, epr_pkg::CfgDataWidth'(0));
		repeat (3) send_echo(1'($urandom_range(1)));
		settle();
		write_reg(epr_pkg::REG_ENABLE, epr_pkg::CfgDataWidth'(1));
		echo_pulse(1, 12);
	endtask

	task automatic test_random_traffic();
		int width;
		for (int round = 0; round < 5; round++) begin
			settle();
			quiet = (round == 2);
			write_reg(epr_pkg::REG_ENABLE, epr_pkg::CfgDataWidth'(1));
			write_reg(epr_pkg::REG_TRIGGER, epr_pkg::CfgDataWidth'($urandom_range(0, 40)));
			case (round)
				1: write_reg(epr_pkg::REG_TIMEOUT,
					epr_pkg::CfgDataWidth'($urandom_range(0, 80)));
				3: write_reg(epr_pkg::REG_TIMEOUT,
					epr_pkg::CfgDataWidth'({epr_pkg::TimeoutWidth{1'b1}}));
				default: write_reg(epr_pkg::REG_TIMEOUT,
					epr_pkg::CfgDataWidth'($urandom_range(200, 3000)));
			endcase
			live_items = 0;
			while (live_items < 50) begin
				if ($urandom_range(99) < 80) begin
					width = ($urandom_range(9) == 0) ? $urandom_range(60, 400)
						: $urandom_range(1, 60);
					echo_pulse($urandom_range(0, 20), width);
				end else begin
					// noise and broken pulses
					repeat ($urandom_range(1, 30)) send_echo(1'($urandom_range(1)));
				end
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		echo_in.valid      <= 1'b0;
		echo_in.echo_level <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_counting_edges();
		test_trigger_lengths();
		test_timeouts();
		test_disable();
		test_random_traffic();

		settle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("[echo_pulse_range_meter] OK");
		else
			$display("[echo_pulse_range_meter] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/epr_pkg.sv
rtl/core/epr_in_if.sv
rtl/core/epr_out_if.sv
rtl/core/epr_regs.sv
rtl/core/epr_cm_conv.sv
rtl/core/epr_core.sv
rtl/core/echo_pulse_range_meter.sv
sim/tb_echo_pulse_range_meter.sv
